>>> sv/b64c_pkg.sv
package b64c_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='
  localparam logic [7:0] PLUS_CHAR = 8'h2B;  // '+'
  localparam logic [7:0] SLASH_CHAR = 8'h2F;  // '/'

  typedef enum logic [1:0] {
    JOB_ENC,
    JOB_DEC,
    JOB_ERR
  } job_kind_t;

  // One group handed from the front end to the output side.
  typedef struct packed {
    job_kind_t       kind;
    logic [3:0][7:0] data;      // raw bytes (encode) or characters (decode)
    logic [1:0]      enc_fill;  // encode: real bytes in group, 1..3
    logic [1:0]      last_idx;  // index of the last result of this group
  } job_t;

  typedef struct packed {
    logic direction;  // 0 encode, 1 decode
    logic clear;      // register write: drop partial group
  } front_ctrl_t;

  function automatic logic [7:0] six_to_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return w + 8'd65;
    end else if (v < 6'd52) begin
      return w + 8'd71;
    end else if (v < 6'd62) begin
      return w - 8'd4;
    end else if (v == 6'd62) begin
      return PLUS_CHAR;
    end else begin
      return SLASH_CHAR;
    end
  endfunction

  function automatic logic [5:0] char_to_six(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'd65;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'd71;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c + 8'd4;
    end else if (c == PLUS_CHAR) begin
      d = 8'd62;
    end else if (c == SLASH_CHAR) begin
      d = 8'd63;
    end
    return d[5:0];
  endfunction

endpackage

>>> sv/b64c_front.sv
module b64c_front (
  input  logic                 clk,
  input  logic                 rst,
  input  b64c_pkg::front_ctrl_t ctrl,
  input  logic                 accept,
  input  logic [7:0]           in_byte,
  input  logic                 message_end,
  output logic                 job_valid,
  output b64c_pkg::job_t       job
);

  logic [2:0][7:0] group_store;
  logic [1:0]      fill_count;
  logic [1:0]      fill_count_next;
  logic [1:0]      slot;
  logic [2:0]      pads;

  always_comb begin
    job             = '0;
    job_valid       = 1'b0;
    fill_count_next = fill_count;
    slot            = (fill_count > 2'd2) ? 2'd2 : fill_count;
    pads            = 3'd0;
    if (!ctrl.direction) begin
      job.kind     = b64c_pkg::JOB_ENC;
      job.last_idx = 2'd3;
      job.enc_fill = slot + 2'd1;
      for (int i = 0; i < 3; i++) begin
        if (i < int'(slot)) job.data[i] = group_store[i];
        else if (i == int'(slot)) job.data[i] = in_byte;
        else job.data[i] = 8'd0;
      end
      if (slot == 2'd2 || message_end) begin
        job_valid       = 1'b1;
        fill_count_next = 2'd0;
      end else begin
        fill_count_next = slot + 2'd1;
      end
    end else begin
      job.data = {in_byte, group_store[2], group_store[1], group_store[0]};
      for (int i = 0; i < 4; i++) begin
        if (job.data[i] == b64c_pkg::PAD_CHAR) pads = pads + 3'd1;
      end
      if (fill_count == 2'd3) begin
        job.kind        = b64c_pkg::JOB_DEC;
        job.last_idx    = (pads == 3'd1) ? 2'd1 : (pads == 3'd2) ? 2'd0 : 2'd2;
        job_valid       = 1'b1;
        fill_count_next = 2'd0;
      end else if (message_end) begin
        job.kind        = b64c_pkg::JOB_ERR;
        job.last_idx    = 2'd0;
        job_valid       = 1'b1;
        fill_count_next = 2'd0;
      end else begin
        fill_count_next = fill_count + 2'd1;
      end
    end
    if (!accept) job_valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= 2'd0;
    end else if (ctrl.clear) begin
      fill_count <= 2'd0;
    end else if (accept) begin
      fill_count <= fill_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_store <= '0;
    end else if (accept && !ctrl.clear) begin
      if (ctrl.direction) begin
        if (fill_count != 2'd3) group_store[fill_count] <= in_byte;
      end else begin
        group_store[slot] <= in_byte;
      end
    end
  end

endmodule

>>> sv/b64c_fifo.sv
module b64c_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  b64c_pkg::job_t wr_data,
  input  logic           rd_en,
  output b64c_pkg::job_t rd_data,
  output logic           full,
  output logic           empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  b64c_pkg::job_t mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      if (wr_en && !rd_en) count <= count + 1'b1;
      else if (rd_en && !wr_en) count <= count - 1'b1;
    end
  end

endmodule

>>> sv/b64c_back.sv
module b64c_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  b64c_pkg::job_t q_data,
  output logic           q_pop,
  input  logic           pop,
  output logic           empty,
  output logic [7:0]     out_byte,
  output logic           run_last,
  output logic           length_error
);

  b64c_pkg::job_t cur;
  logic           cur_valid;
  logic [1:0]     idx;
  logic           done;
  logic [5:0]     sext;
  logic [3:0][5:0] v;

  assign empty = !cur_valid;
  assign run_last = (idx == cur.last_idx);
  assign done  = !cur_valid || (pop && run_last);
  assign q_pop = done && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (done) begin
      cur_valid <= !q_empty;
      idx       <= 2'd0;
    end else if (pop) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) v[i] = b64c_pkg::char_to_six(cur.data[i]);
    unique case (idx)
      2'd0: sext = cur.data[0][7:2];
      2'd1: sext = {cur.data[0][1:0], cur.data[1][7:4]};
      2'd2: sext = {cur.data[1][3:0], cur.data[2][7:6]};
      default: sext = cur.data[2][5:0];
    endcase
    length_error = 1'b0;
    out_byte     = 8'd0;
    unique case (cur.kind)
      b64c_pkg::JOB_ENC: begin
        out_byte = (idx > cur.enc_fill) ? b64c_pkg::PAD_CHAR : b64c_pkg::six_to_char(sext);
      end
      b64c_pkg::JOB_DEC: begin
        unique case (idx)
          2'd0: out_byte = {v[0], v[1][5:4]};
          2'd1: out_byte = {v[1][3:0], v[2][5:2]};
          default: out_byte = {v[2][1:0], v[3]};
        endcase
      end
      default: length_error = 1'b1;
    endcase
  end

endmodule

>>> sv/base64_codec_top.sv
// Streaming base64 codec, standard alphabet. The direction register (byte
// address 0, bit 0) picks encode (0) or decode (1); write it only while the
// block is idle, and every write drops a partially gathered group. Input
// bytes are taken one per cycle whenever the group queue has room: the front
// end gathers a group (three bytes or four characters) and hands the whole
// group to the queue in the cycle that completes it. The output side
// transfers one result per cycle from the head group while pop is held and
// a group is ready, so the result port sets the sustained rate: encode takes
// three input bytes per four results, decode up to one character per cycle.
// A group's first result reaches the result ports once the group has passed
// through the queue into the output register. A decode message that ends
// mid-group yields one result with length_error set; earlier groups stand.
module base64_codec_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  // item side
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        message_end,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        length_error,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_DIRECTION = 1'b0;  // register index, from paddr[2]

  logic                  direction;
  logic                  cfg_wr;
  logic                  accept;
  logic                  job_valid;
  b64c_pkg::job_t        job;
  b64c_pkg::job_t        q_data;
  logic                  q_empty;
  logic                  q_pop;
  b64c_pkg::front_ctrl_t ctrl;

  // register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DIRECTION);
  assign prdata = (paddr[2] == REG_DIRECTION) ? {31'd0, direction} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
    end else if (cfg_wr) begin
      direction <= pwdata[0];
    end
  end

  // any input transfer needs queue room, since it may close a group
  assign accept = push && !full;
  assign ctrl   = '{direction: direction, clear: cfg_wr};

  b64c_front u_front (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .accept      (accept),
    .in_byte     (in_byte),
    .message_end (message_end),
    .job_valid   (job_valid),
    .job         (job)
  );

  b64c_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_valid),
    .wr_data (job),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .full    (full),
    .empty   (q_empty)
  );

  b64c_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .out_byte     (out_byte),
    .run_last     (run_last),
    .length_error (length_error)
  );

endmodule
